### design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition always implies a consequence in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("implication check failed");

// Checks that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### design/rmj_pkg.sv
`timescale 1ns / 1ps

package rmj_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WW        = 128;
    localparam int CW        = WW + 32;
    localparam int QW        = 32;
    localparam int RW        = 64;
    localparam int DIV_LAT   = QW + 1;

    localparam logic [31:0] FIX_ONE = 32'(1) << FRAC_BITS;
    localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_MAX = 32'h8000_0000;

    typedef struct packed {
        logic [31:0] mag_x;
        logic [31:0] mag_y;
        logic        neg_x;
        logic        neg_y;
        logic [63:0] cross_mag;
        logic        cross_neg;
        logic [63:0] sq_dist;
        logic        degen;
    } rmj_side_t;

    typedef struct packed {
        logic [5:0] neg;
        logic       degen;
    } rmj_sign_t;

    function automatic logic [31:0] encode(logic neg, logic sat, logic [31:0] q);
        logic [31:0] r;
        if (sat) begin
            r = neg ? NEG_MAX : POS_MAX;
        end else if (!neg) begin
            r = (q > POS_MAX) ? POS_MAX : q;
        end else begin
            r = (q > NEG_MAX) ? NEG_MAX : (~q + 32'd1);
        end
        return r;
    endfunction

endpackage

### design/rmj_sqrt.sv
`timescale 1ns / 1ps

module rmj_sqrt (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  rmj_pkg::rmj_side_t  in_side,
    output logic                out_valid,
    output logic [63:0]         root,
    output rmj_pkg::rmj_side_t  out_side
);
    import rmj_pkg::*;

    logic [RW-1:0] root_reg  [RW];
    logic [WW-1:0] rem_reg   [RW];
    rmj_side_t     side_reg  [RW];
    logic          valid_reg [RW];

    genvar k;
    generate
        for (k = 0; k < RW; k++) begin : g_stage
            localparam int BIT = RW - 1 - k;
            logic [RW-1:0] root_in;
            logic [WW-1:0] rem_in;
            logic          valid_in;
            rmj_side_t     side_in;
            logic [WW-1:0] trial;
            logic [RW-1:0] root_next;
            logic [WW-1:0] rem_next;

            if (k == 0) begin : g_first
                assign root_in  = '0;
                assign rem_in   = {in_side.sq_dist, {(WW - 64){1'b0}}};
                assign valid_in = in_valid;
                assign side_in  = in_side;
            end else begin : g_rest
                assign root_in  = root_reg[k-1];
                assign rem_in   = rem_reg[k-1];
                assign valid_in = valid_reg[k-1];
                assign side_in  = side_reg[k-1];
            end

            always_comb
            begin
                trial = ({{(WW - RW){1'b0}}, root_in} << (BIT + 1))
                      | ({{(WW - 1){1'b0}}, 1'b1} << (2 * BIT));
                if (rem_in >= trial)
                begin
                    rem_next  = rem_in - trial;
                    root_next = root_in | ({{(RW - 1){1'b0}}, 1'b1} << BIT);
                end
                else
                begin
                    rem_next  = rem_in;
                    root_next = root_in;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[k] <= 1'b0;
                else
                    valid_reg[k] <= valid_in;
            end

            always_ff @(posedge clk)
            begin
                root_reg[k] <= root_next;
                rem_reg[k]  <= rem_next;
                side_reg[k] <= side_in;
            end
        end
    endgenerate

    assign out_valid = valid_reg[RW-1];
    assign root      = root_reg[RW-1];
    assign out_side  = side_reg[RW-1];

endmodule

### design/rmj_div.sv
`timescale 1ns / 1ps

module rmj_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [127:0] num,
    input  logic [127:0] den,
    output logic        out_valid,
    output logic [31:0] quot,
    output logic        sat
);
    import rmj_pkg::*;

    logic [WW-1:0] rem_reg   [QW+1];
    logic [WW-1:0] den_reg   [QW+1];
    logic [QW-1:0] q_reg     [QW+1];
    logic          sat_reg   [QW+1];
    logic          zero_reg  [QW+1];
    logic          valid_reg [QW+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg[0] <= 1'b0;
        else
            valid_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= num;
        den_reg[0]  <= den;
        q_reg[0]    <= '0;
        zero_reg[0] <= (num == '0);
        sat_reg[0]  <= (num != '0) && ({32'b0, num} >= {den, 32'b0});
    end

    genvar j;
    generate
        for (j = 1; j <= QW; j++) begin : g_step
            localparam int BIT = QW - j;
            logic [CW-1:0] trial;
            logic          ge;

            assign trial = {{(CW - WW){1'b0}}, den_reg[j-1]} << BIT;
            assign ge    = {{(CW - WW){1'b0}}, rem_reg[j-1]} >= trial;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[j] <= 1'b0;
                else
                    valid_reg[j] <= valid_reg[j-1];
            end

            always_ff @(posedge clk)
            begin
                rem_reg[j]  <= ge ? WW'({{(CW - WW){1'b0}}, rem_reg[j-1]} - trial)
                                  : rem_reg[j-1];
                q_reg[j]    <= q_reg[j-1] | (ge ? (QW'(1) << BIT) : '0);
                den_reg[j]  <= den_reg[j-1];
                sat_reg[j]  <= sat_reg[j-1];
                zero_reg[j] <= zero_reg[j-1];
            end
        end
    endgenerate

    assign out_valid = valid_reg[QW];
    assign quot      = zero_reg[QW] ? '0 : q_reg[QW];
    assign sat       = sat_reg[QW];

endmodule

### design/radar_measurement_jacobian.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Radar measurement Jacobian for a 2-D state: one transfer in per cycle at full
// rate, since busy is always low, and each result appears as a one-cycle done
// strobe that the receiver cannot stall. Each result passes through the 64-stage
// bit-per-stage square root and the 33-stage dividers.
module radar_measurement_jacobian (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [31:0]  pos_x,
    input  logic signed [31:0]  pos_y,
    input  logic signed [31:0]  vel_x,
    input  logic signed [31:0]  vel_y,
    output logic                done,
    output logic signed [31:0]  d_range_d_px,
    output logic signed [31:0]  d_range_d_py,
    output logic signed [31:0]  d_bearing_d_px,
    output logic signed [31:0]  d_bearing_d_py,
    output logic signed [31:0]  d_rate_d_px,
    output logic signed [31:0]  d_rate_d_py,
    output logic                degenerate,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import rmj_pkg::*;

    logic [15:0] thr_reg;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign prdata = paddr[2] ? 32'd0 : {16'd0, thr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= 16'd7;
        else if (psel && penable && pwrite && !paddr[2])
            thr_reg <= pwdata[15:0];
    end

    // Stage 0: sign and magnitude split.
    logic        v0_reg;
    logic [31:0] mx_reg, my_reg, mvx_reg, mvy_reg;
    logic        nx_reg, ny_reg, nvx_reg, nvy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else
            v0_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        nx_reg  <= pos_x[31];
        ny_reg  <= pos_y[31];
        nvx_reg <= vel_x[31];
        nvy_reg <= vel_y[31];
        mx_reg  <= pos_x[31] ? (~pos_x + 32'd1) : pos_x;
        my_reg  <= pos_y[31] ? (~pos_y + 32'd1) : pos_y;
        mvx_reg <= vel_x[31] ? (~vel_x + 32'd1) : vel_x;
        mvy_reg <= vel_y[31] ? (~vel_y + 32'd1) : vel_y;
    end

    // Stage 1: products.
    logic        v1_reg;
    logic [63:0] sqx_reg, sqy_reg, t1_reg, t2_reg;
    logic [31:0] mx1_reg, my1_reg;
    logic        nx1_reg, ny1_reg, s1_reg, s2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= v0_reg;
    end

    always_ff @(posedge clk)
    begin
        sqx_reg <= mx_reg * mx_reg;
        sqy_reg <= my_reg * my_reg;
        t1_reg  <= mvx_reg * my_reg;
        t2_reg  <= mvy_reg * mx_reg;
        mx1_reg <= mx_reg;
        my1_reg <= my_reg;
        nx1_reg <= nx_reg;
        ny1_reg <= ny_reg;
        s1_reg  <= nvx_reg ^ ny_reg;
        s2_reg  <= !(nvy_reg ^ nx_reg);
    end

    // Stage 2: squared distance, cross term, degenerate test.
    logic      v2_reg;
    rmj_side_t side2_reg;
    rmj_side_t side2_next;

    always_comb
    begin
        side2_next.mag_x   = mx1_reg;
        side2_next.mag_y   = my1_reg;
        side2_next.neg_x   = nx1_reg;
        side2_next.neg_y   = ny1_reg;
        side2_next.sq_dist = sqx_reg + sqy_reg;
        side2_next.degen   = side2_next.sq_dist < ({48'd0, thr_reg} << FRAC_BITS);
        if (s1_reg == s2_reg)
        begin
            side2_next.cross_mag = t1_reg + t2_reg;
            side2_next.cross_neg = s1_reg;
        end
        else if (t1_reg >= t2_reg)
        begin
            side2_next.cross_mag = t1_reg - t2_reg;
            side2_next.cross_neg = s1_reg;
        end
        else
        begin
            side2_next.cross_mag = t2_reg - t1_reg;
            side2_next.cross_neg = s2_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        side2_reg <= side2_next;
    end

    logic        sq_valid;
    logic [63:0] sq_root;
    rmj_side_t   sq_side;

    rmj_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v2_reg),
        .in_side   (side2_reg),
        .out_valid (sq_valid),
        .root      (sq_root),
        .out_side  (sq_side)
    );

    // Stage 3: partial products of s*R and p*cross.
    logic        v3_reg;
    logic [63:0] sr00_reg, sr01_reg, sr10_reg, sr11_reg;
    logic [63:0] cy0_reg, cy1_reg, cx0_reg, cx1_reg;
    logic [63:0] root3_reg;
    rmj_side_t   side3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else
            v3_reg <= sq_valid;
    end

    always_ff @(posedge clk)
    begin
        sr00_reg  <= sq_side.sq_dist[31:0]  * sq_root[31:0];
        sr01_reg  <= sq_side.sq_dist[31:0]  * sq_root[63:32];
        sr10_reg  <= sq_side.sq_dist[63:32] * sq_root[31:0];
        sr11_reg  <= sq_side.sq_dist[63:32] * sq_root[63:32];
        cy0_reg   <= sq_side.mag_y * sq_side.cross_mag[31:0];
        cy1_reg   <= sq_side.mag_y * sq_side.cross_mag[63:32];
        cx0_reg   <= sq_side.mag_x * sq_side.cross_mag[31:0];
        cx1_reg   <= sq_side.mag_x * sq_side.cross_mag[63:32];
        root3_reg <= sq_root;
        side3_reg <= sq_side;
    end

    // Stage 4: numerators and divisors.
    logic          v4_reg;
    logic [WW-1:0] num_reg [6];
    logic [WW-1:0] den_reg [6];
    rmj_sign_t     sign4_reg;
    logic [WW-1:0] sr_full, cy_full, cx_full;
    logic [WW-1:0] ext_x, ext_y;

    always_comb
    begin
        sr_full = {64'd0, sr00_reg}
                + ({64'd0, sr01_reg} << 32)
                + ({64'd0, sr10_reg} << 32)
                + ({64'd0, sr11_reg} << 64);
        cy_full = {64'd0, cy0_reg} + ({64'd0, cy1_reg} << 32);
        cx_full = {64'd0, cx0_reg} + ({64'd0, cx1_reg} << 32);
        ext_x   = {96'd0, side3_reg.mag_x};
        ext_y   = {96'd0, side3_reg.mag_y};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        num_reg[0] <= ext_x << (FRAC_BITS + 32);
        num_reg[1] <= ext_y << (FRAC_BITS + 32);
        num_reg[2] <= ext_y << (2 * FRAC_BITS);
        num_reg[3] <= ext_x << (2 * FRAC_BITS);
        num_reg[4] <= cy_full << FRAC_BITS;
        num_reg[5] <= cx_full << FRAC_BITS;
        den_reg[0] <= {64'd0, root3_reg};
        den_reg[1] <= {64'd0, root3_reg};
        den_reg[2] <= {64'd0, side3_reg.sq_dist};
        den_reg[3] <= {64'd0, side3_reg.sq_dist};
        den_reg[4] <= sr_full >> 32;
        den_reg[5] <= sr_full >> 32;
        sign4_reg.neg[0] <= side3_reg.neg_x;
        sign4_reg.neg[1] <= side3_reg.neg_y;
        sign4_reg.neg[2] <= !side3_reg.neg_y;
        sign4_reg.neg[3] <= side3_reg.neg_x;
        sign4_reg.neg[4] <= side3_reg.neg_y ^ side3_reg.cross_neg;
        sign4_reg.neg[5] <= !(side3_reg.neg_x ^ side3_reg.cross_neg);
        sign4_reg.degen  <= side3_reg.degen;
    end

    logic [5:0]  div_valid;
    logic [31:0] div_quot [6];
    logic [5:0]  div_sat;

    genvar d;
    generate
        for (d = 0; d < 6; d++) begin : g_div
            rmj_div u_div (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (v4_reg),
                .num       (num_reg[d]),
                .den       (den_reg[d]),
                .out_valid (div_valid[d]),
                .quot      (div_quot[d]),
                .sat       (div_sat[d])
            );
        end
    endgenerate

    rmj_sign_t sign_dly_reg [DIV_LAT];

    always_ff @(posedge clk)
    begin
        sign_dly_reg[0] <= sign4_reg;
        for (int n = 1; n < DIV_LAT; n++)
            sign_dly_reg[n] <= sign_dly_reg[n-1];
    end

    rmj_sign_t   sign_out;
    logic [31:0] enc [6];

    assign sign_out = sign_dly_reg[DIV_LAT-1];

    always_comb
    begin
        for (int n = 0; n < 6; n++)
            enc[n] = sign_out.degen ? FIX_ONE
                                    : encode(sign_out.neg[n], div_sat[n], div_quot[n]);
    end

    logic        done_reg;
    logic [31:0] out_reg [6];
    logic        degen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= &div_valid;
    end

    always_ff @(posedge clk)
    begin
        for (int n = 0; n < 6; n++)
            out_reg[n] <= enc[n];
        degen_reg <= sign_out.degen;
    end

    assign done           = done_reg;
    assign d_range_d_px   = out_reg[0];
    assign d_range_d_py   = out_reg[1];
    assign d_bearing_d_px = out_reg[2];
    assign d_bearing_d_py = out_reg[3];
    assign d_rate_d_px    = out_reg[4];
    assign d_rate_d_py    = out_reg[5];
    assign degenerate     = degen_reg;

    `ASSERT_IMPLIES(a_degen_one, clk, rst_n, done && degenerate, d_range_d_px == FIX_ONE && d_rate_d_py == FIX_ONE)
    `ASSERT_IMPLIES(a_div_lockstep, clk, rst_n, div_valid[0], &div_valid)
    `ASSERT_NEXT(a_start_enters, clk, rst_n, start, v0_reg)

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import rmj_pkg::*;

    localparam logic [2:0] ADDR_THRESHOLD = 3'd0;
    localparam int PIPE_DEPTH   = 110;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 160;

    typedef struct {
        logic [31:0] d[6];
        logic        degen;
    } jacobian_t;

    typedef struct {
        logic [31:0] f[4];
        logic        known;
        jacobian_t   want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] pos_x, pos_y, vel_x, vel_y;
    logic        done;
    logic [31:0] d_range_d_px, d_range_d_py, d_bearing_d_px, d_bearing_d_py;
    logic [31:0] d_rate_d_px, d_rate_d_py;
    logic        degenerate;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;

    radar_measurement_jacobian dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .pos_x(pos_x), .pos_y(pos_y), .vel_x(vel_x), .vel_y(vel_y),
        .done(done),
        .d_range_d_px(d_range_d_px), .d_range_d_py(d_range_d_py),
        .d_bearing_d_px(d_bearing_d_px), .d_bearing_d_py(d_bearing_d_py),
        .d_rate_d_px(d_rate_d_px), .d_rate_d_py(d_rate_d_py),
        .degenerate(degenerate),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    logic [15:0] threshold;
    jacobian_t   pending_results[$];
    stim_row_t   directed[$];
    int          accepted;
    int          errors;
    int          cycles;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL radar_measurement_jacobian");
            $finish;
        end
    end

    function automatic void split_mag(input logic [31:0] raw, output logic [31:0] mag,
                                      output logic neg);
        neg = raw[31];
        mag = neg ? (~raw + 32'd1) : raw;
    endfunction

    function automatic logic [31:0] clamp_q(input logic neg, input logic [191:0] num,
                                            input logic [191:0] den);
        logic [191:0] q;
        if (num == 0)
            q = 0;
        else if (den == 0)
            q = 192'd1 << 32;
        else
            q = num / den;
        if (!neg)
            return (q > 192'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
        if (q > 192'h8000_0000)
            return 32'h8000_0000;
        return ~q[31:0] + 32'd1;
    endfunction

    function automatic logic [63:0] range_root(input logic [127:0] n);
        logic [127:0] c;
        logic [63:0]  res;
        res = 0;
        for (int i = 63; i >= 0; i--)
        begin
            c = {64'd0, res | (64'd1 << i)};
            if (c * c <= n)
                res = c[63:0];
        end
        return res;
    endfunction

    function automatic jacobian_t predict_jacobian(input logic [31:0] f[4]);
        jacobian_t    j;
        logic [31:0]  mx, my, mvx, mvy;
        logic         nx, ny, nvx, nvy, s1, s2, cneg;
        logic [63:0]  s, t1, t2, cmag, r;
        logic [191:0] k;
        split_mag(f[0], mx, nx);
        split_mag(f[1], my, ny);
        split_mag(f[2], mvx, nvx);
        split_mag(f[3], mvy, nvy);
        s = 64'(mx) * 64'(mx) + 64'(my) * 64'(my);
        if (s < (64'(threshold) << FRAC_BITS))
        begin
            for (int i = 0; i < 6; i++)
                j.d[i] = FIX_ONE;
            j.degen = 1'b1;
            return j;
        end
        t1 = 64'(mvx) * 64'(my);
        s1 = nvx != ny;
        t2 = 64'(mvy) * 64'(mx);
        s2 = nvy == nx;
        if (s1 == s2)
        begin
            cmag = t1 + t2;
            cneg = s1;
        end
        else if (t1 >= t2)
        begin
            cmag = t1 - t2;
            cneg = s1;
        end
        else
        begin
            cmag = t2 - t1;
            cneg = s2;
        end
        r = range_root({s, 64'd0});
        k = (192'(s) * 192'(r)) >> 32;
        j.d[0] = clamp_q(nx, 192'(mx) << (FRAC_BITS + 32), 192'(r));
        j.d[1] = clamp_q(ny, 192'(my) << (FRAC_BITS + 32), 192'(r));
        j.d[2] = clamp_q(!ny, 192'(my) << (2 * FRAC_BITS), 192'(s));
        j.d[3] = clamp_q(nx, 192'(mx) << (2 * FRAC_BITS), 192'(s));
        j.d[4] = clamp_q(ny != cneg, (192'(my) * 192'(cmag)) << FRAC_BITS, k);
        j.d[5] = clamp_q(nx == cneg, (192'(mx) * 192'(cmag)) << FRAC_BITS, k);
        j.degen = 1'b0;
        return j;
    endfunction

    always @(posedge clk)
    begin
        logic [31:0] fields[4];
        logic [31:0] got[6];
        jacobian_t   want;
        if (rst_n && start && !busy)
        begin
            fields = '{pos_x, pos_y, vel_x, vel_y};
            if (accepted < directed.size() && directed[accepted].known)
                pending_results.push_back(directed[accepted].want);
            else
                pending_results.push_back(predict_jacobian(fields));
            accepted++;
        end
        if (rst_n && done)
        begin
            got = '{d_range_d_px, d_range_d_py, d_bearing_d_px, d_bearing_d_py,
                    d_rate_d_px, d_rate_d_py};
            if (pending_results.size() == 0)
            begin
                $display("%0t: result transfer with nothing expected", $time);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                for (int i = 0; i < 6; i++)
                    if (got[i] !== want.d[i])
                    begin
                        $display("%0t: output %0d expected %h actual %h", $time, i,
                                 want.d[i], got[i]);
                        errors++;
                    end
                if (degenerate !== want.degen)
                begin
                    $display("%0t: degenerate expected %b actual %b", $time, want.degen,
                             degenerate);
                    errors++;
                end
            end
        end
    end

    task automatic write_threshold(input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= ADDR_THRESHOLD;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        threshold = value[15:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_state(input logic [31:0] f[4], input int gap);
        repeat (gap)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start <= 1'b1;
        pos_x <= f[0];
        pos_y <= f[1];
        vel_x <= f[2];
        vel_y <= f[3];
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic drain();
        wait (pending_results.size() == 0);
        repeat (PIPE_DEPTH) @(posedge clk);
    endtask

    function automatic logic [31:0] random_value(input int mode);
        case (mode)
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 262143)) - 131072);
            2: return 32'($signed($urandom_range(0, 2047)) - 1024);
            3: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: return 32'($signed($urandom_range(0, 2 ** 24)) - 2 ** 23);
        endcase
    endfunction

    task automatic run_random(input int count);
        logic [31:0] f[4];
        int          gap;
        int          burst;
        burst = 0;
        for (int n = 0; n < count; n++)
        begin
            for (int i = 0; i < 4; i++)
                f[i] = random_value($urandom_range(0, 4));
            if (burst > 0)
            begin
                gap = 0;
                burst--;
            end
            else
            begin
                gap = $urandom_range(0, 13);
                if ($urandom_range(0, 15) == 0)
                    burst = $urandom_range(5, 30);
            end
            send_state(f, gap);
        end
        @(negedge clk);
        start <= 1'b0;
    endtask

    function automatic stim_row_t row(input logic [31:0] a, input logic [31:0] b,
                                      input logic [31:0] c, input logic [31:0] d);
        stim_row_t s;
        s.f = '{a, b, c, d};
        s.known = 1'b0;
        return s;
    endfunction

    initial
    begin
        stim_row_t s;
        logic [31:0] zero_state[4];
        errors   = 0;
        cycles   = 0;
        accepted = 0;
        rst_n    = 1'b0;
        start    = 1'b0;
        pos_x    = '0;
        pos_y    = '0;
        vel_x    = '0;
        vel_y    = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        threshold = 16'd7;

        // Origin falls under the reset threshold: all six outputs read 1.0.
        s = row(0, 0, 0, 0);
        s.known = 1'b1;
        s.want.d = '{FIX_ONE, FIX_ONE, FIX_ONE, FIX_ONE, FIX_ONE, FIX_ONE};
        s.want.degen = 1'b1;
        directed.push_back(s);
        // Unit distance on the x axis, moving at unit speed along x.
        s = row(32'h0001_0000, 0, 32'h0001_0000, 0);
        s.known = 1'b1;
        s.want.d = '{32'h0001_0000, 0, 0, 32'h0001_0000, 0, 0};
        s.want.degen = 1'b0;
        directed.push_back(s);
        // Just below and just above the default threshold.
        directed.push_back(row(677, 0, 5, 7));
        directed.push_back(row(678, 0, 5, 7));
        directed.push_back(row(0, -678, -5, 7));
        directed.push_back(row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        directed.push_back(row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        directed.push_back(row(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
        directed.push_back(row(32'h7FFF_FFFF, 0, 0, 32'h8000_0000));
        directed.push_back(row(1000, 32'hFFFF_FC18, 32'hFFFF_FFFF, 1));
        directed.push_back(row(-1000, 1000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        directed.push_back(row(32'h0003_0000, 32'h0004_0000, 32'h0001_0000, 32'hFFFF_0000));
        directed.push_back(row(-32'h0003_0000, 32'h0004_0000, -32'h0002_0000, 32'h0001_8000));
        directed.push_back(row(1, 32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA));

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed[i])
            send_state(directed[i].f, $urandom_range(0, 3));
        @(negedge clk);
        start <= 1'b0;
        run_random(RANDOM_ITEMS);
        drain();

        // With no threshold, the origin reaches the dividers with a zero divisor.
        write_threshold(32'd0);
        zero_state = '{0, 0, 0, 0};
        send_state(zero_state, 0);
        zero_state = '{0, 0, 32'h7FFF_FFFF, 32'h8000_0000};
        send_state(zero_state, 0);
        zero_state = '{1, 0, 0, 0};
        send_state(zero_state, 0);
        run_random(RANDOM_ITEMS);
        drain();

        write_threshold(32'd65535);
        for (int i = 0; i < 4; i++)
            send_state(directed[i].f, 1);
        run_random(RANDOM_ITEMS);
        drain();

        // Upper bits of the write data fall outside the register.
        write_threshold({16'hDEAD, 16'($urandom_range(1, 65534))});
        run_random(RANDOM_ITEMS);
        drain();

        write_threshold(32'd7);
        run_random(RANDOM_ITEMS);
        drain();

        if (errors == 0)
            $display("PASS radar_measurement_jacobian");
        else
            $display("FAIL radar_measurement_jacobian");
        $finish;
    end

endmodule

### filelist.f
+incdir+design
design/rmj_pkg.sv
design/rmj_sqrt.sv
design/rmj_div.sv
design/radar_measurement_jacobian.sv
dv/tb.sv
